>>> rtl/su2pa_pkg.sv
// su2pa_pkg: number formats, operand and control types, helper functions
// for the su2 plaquette accumulator; used by every rtl file of the block.
// no dependencies.
package su2pa_pkg;

	// component format: signed, two integer bits, the rest fraction
	localparam int CompBits  = 18;
	localparam int FracBits  = CompBits - 2;
	localparam int FieldBits = 2 * CompBits;
	localparam int AccBits   = 48;

	// datapath widths of the shared complex multiply-add unit
	localparam int OpBits   = CompBits + 1;          // conjugated operand, exact
	localparam int ProdBits = CompBits + OpBits;     // full real product
	localparam int RndBits  = ProdBits - FracBits;   // product after rounding
	localparam int TermBits = RndBits + 1;           // re/im of one complex product
	localparam int SumBits  = TermBits + 1;          // sum of two complex products

	localparam logic signed [ProdBits-1:0] RndHalf = ProdBits'(1) << (FracBits - 1);

	// sequencer: issue steps 0..9, one drain step
	localparam int LastStep = 10;
	localparam int StepBits = $clog2(LastStep + 1);

	typedef logic signed [CompBits-1:0] comp_t;

	typedef struct packed {
		comp_t re;
		comp_t im;
	} cplx_t;

	// destination of a finished two-term sum
	typedef enum logic [2:0] {
		DstS11,
		DstS12,
		DstT11,
		DstT12,
		DstP
	} dest_t;

	// control that travels with one complex product through the unit
	typedef struct packed {
		logic  issue;  // a product enters the unit
		logic  conj;   // conjugate the second operand
		logic  sub;    // subtract this product from the running sum
		logic  fin;    // second term: saturate and deliver
		dest_t dest;
	} mac_ctl_t;

	typedef struct packed {
		logic  valid;
		dest_t dest;
		cplx_t value;
	} mac_res_t;

	// command from the sequencer to the accumulator bank
	typedef struct packed {
		logic upd;
		logic is_time;
		logic last;
	} acc_cmd_t;

	// split a packed field, real part high
	function automatic cplx_t unpack_cplx(input logic [FieldBits-1:0] f);
		cplx_t c;
		c.re = f[FieldBits-1:CompBits];
		c.im = f[CompBits-1:0];
		return c;
	endfunction

	// add half an lsb, floor shift to the component fraction
	function automatic logic signed [RndBits-1:0] round_prod(
		input logic signed [ProdBits-1:0] p);
		logic signed [ProdBits-1:0] t;
		t = p + RndHalf;
		return t[ProdBits-1:FracBits];
	endfunction

	// clamp a two-term sum to the component range
	function automatic comp_t sat_comp(input logic signed [SumBits-1:0] v);
		logic [SumBits-CompBits:0] top;
		comp_t r;
		top = v[SumBits-1:CompBits-1];
		if ((&top) || !(|top)) begin
			r = v[CompBits-1:0];
		end else begin
			r = {v[SumBits-1], {(CompBits-1){~v[SumBits-1]}}};
		end
		return r;
	endfunction

endpackage

>>> rtl/su2pa_if.sv
// su2pa_in_if and su2pa_out_if: valid/ready channels of the plaquette
// accumulator, one plaquette in, one pair of sums out.
// depends on su2pa_pkg.
interface su2pa_in_if;
	import su2pa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [FieldBits-1:0] link1_diag;
	logic [FieldBits-1:0] link1_offdiag;
	logic [FieldBits-1:0] link2_diag;
	logic [FieldBits-1:0] link2_offdiag;
	logic [FieldBits-1:0] link3_diag;
	logic [FieldBits-1:0] link3_offdiag;
	logic [FieldBits-1:0] link4_diag;
	logic [FieldBits-1:0] link4_offdiag;
	logic                 is_time;
	logic                 last;

	modport source (
		output valid, link1_diag, link1_offdiag, link2_diag, link2_offdiag,
		output link3_diag, link3_offdiag, link4_diag, link4_offdiag, is_time, last,
		input  ready
	);

	modport sink (
		input  valid, link1_diag, link1_offdiag, link2_diag, link2_offdiag,
		input  link3_diag, link3_offdiag, link4_diag, link4_offdiag, is_time, last,
		output ready
	);
endinterface

interface su2pa_out_if;
	import su2pa_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [AccBits-1:0] space_sum;
	logic signed [AccBits-1:0] time_sum;

	modport source (
		output valid, space_sum, time_sum,
		input  ready
	);

	modport sink (
		input  valid, space_sum, time_sum,
		output ready
	);
endinterface

>>> rtl/su2pa_cmac.sv
// su2pa_cmac: shared complex multiply-add unit, one complex product per cycle,
// products registered, then rounded and summed in pairs with saturation.
// depends on su2pa_pkg.
module su2pa_cmac (
	input  logic                clk,
	input  logic                arst_n,
	input  su2pa_pkg::mac_ctl_t ctl,
	input  su2pa_pkg::cplx_t    x,
	input  su2pa_pkg::cplx_t    y,
	output su2pa_pkg::mac_res_t res
);
	import su2pa_pkg::*;

	logic signed [OpBits-1:0]   y_re;
	logic signed [OpBits-1:0]   y_im;
	logic signed [ProdBits-1:0] p_rr_s1;
	logic signed [ProdBits-1:0] p_ii_s1;
	logic signed [ProdBits-1:0] p_ri_s1;
	logic signed [ProdBits-1:0] p_ir_s1;
	mac_ctl_t                   ctl_s1;
	logic signed [RndBits-1:0]  r_rr;
	logic signed [RndBits-1:0]  r_ii;
	logic signed [RndBits-1:0]  r_ri;
	logic signed [RndBits-1:0]  r_ir;
	logic signed [TermBits-1:0] t_re;
	logic signed [TermBits-1:0] t_im;
	logic signed [TermBits-1:0] part_re_q;
	logic signed [TermBits-1:0] part_im_q;
	logic signed [SumBits-1:0]  s_re;
	logic signed [SumBits-1:0]  s_im;

	// exact conjugate of the second operand
	assign y_re = OpBits'(y.re);
	assign y_im = ctl.conj ? -OpBits'(y.im) : OpBits'(y.im);

	// stage 1: four real products
	always_ff @(posedge clk) begin
		p_rr_s1 <= ProdBits'(x.re) * ProdBits'(y_re);
		p_ii_s1 <= ProdBits'(x.im) * ProdBits'(y_im);
		p_ri_s1 <= ProdBits'(x.re) * ProdBits'(y_im);
		p_ir_s1 <= ProdBits'(x.im) * ProdBits'(y_re);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	// stage 2: round each product, form the signed complex term
	always_comb begin
		r_rr = round_prod(p_rr_s1);
		r_ii = round_prod(p_ii_s1);
		r_ri = round_prod(p_ri_s1);
		r_ir = round_prod(p_ir_s1);
		t_re = TermBits'(r_rr) - TermBits'(r_ii);
		t_im = TermBits'(r_ri) + TermBits'(r_ir);
		if (ctl_s1.sub) begin
			t_re = -t_re;
			t_im = -t_im;
		end
		s_re = SumBits'(part_re_q) + SumBits'(t_re);
		s_im = SumBits'(part_im_q) + SumBits'(t_im);
	end

	// hold the first term of a pair
	always_ff @(posedge clk) begin
		if (ctl_s1.issue && !ctl_s1.fin) begin
			part_re_q <= t_re;
			part_im_q <= t_im;
		end
	end

	// second term closes the pair
	always_comb begin
		res.valid    = ctl_s1.issue && ctl_s1.fin;
		res.dest     = ctl_s1.dest;
		res.value.re = sat_comp(s_re);
		res.value.im = sat_comp(s_im);
	end

endmodule

>>> rtl/su2pa_acc.sv
// su2pa_acc: saturating space and time accumulators and the output register
// that holds both sums until the transaction is taken.
// depends on su2pa_pkg.
module su2pa_acc (
	input  logic                             clk,
	input  logic                             arst_n,
	input  su2pa_pkg::acc_cmd_t              cmd,
	input  su2pa_pkg::comp_t                 pv,
	input  logic                             ready,
	output logic                             free,
	output logic                             valid,
	output logic signed [su2pa_pkg::AccBits-1:0] space_sum,
	output logic signed [su2pa_pkg::AccBits-1:0] time_sum
);
	import su2pa_pkg::*;

	localparam int AccExtBits = AccBits + 1;

	logic signed [AccBits-1:0]    space_q;
	logic signed [AccBits-1:0]    time_q;
	logic signed [AccBits-1:0]    sel;
	logic signed [AccExtBits-1:0] diff;
	logic signed [AccBits-1:0]    res_sat;
	logic signed [AccBits-1:0]    space_nx;
	logic signed [AccBits-1:0]    time_nx;
	logic signed [AccBits-1:0]    space_out_q;
	logic signed [AccBits-1:0]    time_out_q;
	logic                         valid_q;
	logic                         do_upd;

	// subtract the plaquette from the selected sum, clamp to 48 bits
	always_comb begin
		sel  = cmd.is_time ? time_q : space_q;
		diff = AccExtBits'(sel) - AccExtBits'(pv);
		if (diff[AccBits] == diff[AccBits-1]) begin
			res_sat = diff[AccBits-1:0];
		end else begin
			res_sat = {diff[AccBits], {(AccBits-1){~diff[AccBits]}}};
		end
		space_nx = cmd.is_time ? space_q : res_sat;
		time_nx  = cmd.is_time ? res_sat : time_q;
	end

	// a final plaquette needs the output register free
	assign free   = !cmd.last || !valid_q || ready;
	assign do_upd = cmd.upd && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_q <= '0;
			time_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (do_upd) begin
				if (cmd.last) begin
					space_q <= '0;
					time_q  <= '0;
				end else begin
					space_q <= space_nx;
					time_q  <= time_nx;
				end
			end
			if (do_upd && cmd.last) begin
				valid_q <= 1'b1;
			end else if (ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (do_upd && cmd.last) begin
			space_out_q <= space_nx;
			time_out_q  <= time_nx;
		end
	end

	assign valid     = valid_q;
	assign space_sum = space_out_q;
	assign time_sum  = time_out_q;

endmodule

>>> rtl/su2_plaquette_accumulator.sv
// su2_plaquette_accumulator: top level, operand registers and step sequencer
// around the shared complex multiply-add unit and the accumulator bank.
// depends on su2pa_pkg, su2pa_if, su2pa_cmac, su2pa_acc.
//
//   channel | modport              | transaction
//   --------+----------------------+---------------------------------------
//   plaq    | su2pa_in_if.sink     | four links, is_time, last
//   sums    | su2pa_out_if.source  | space_sum, time_sum (after a last item)
//
// one plaquette at a time: ten complex products are issued one per cycle on
// the shared multiply-add unit, then a drain step and an accumulator update
// step follow before the input is ready again.
// arst_n clears the sequencer, both accumulators and the output valid.
// a last item waits in the update step while the previous sums are not taken.
module su2_plaquette_accumulator (
	input logic         clk,
	input logic         arst_n,
	su2pa_in_if.sink    plaq,
	su2pa_out_if.source sums
);
	import su2pa_pkg::*;

	typedef enum logic [2:0] {
		StIdle = 3'b001,
		StRun  = 3'b010,
		StUpd  = 3'b100
	} state_t;

	state_t                state_q;
	logic [StepBits-1:0]   step_q;
	logic                  accept;
	cplx_t                 a1_q, b1_q, a2_q, b2_q, a3_q, b3_q, a4_q, b4_q;
	logic                  is_time_q;
	logic                  last_q;
	cplx_t                 s11_q, s12_q, t11_q, t12_q;
	comp_t                 p_q;
	mac_ctl_t              ctl;
	cplx_t                 x;
	cplx_t                 y;
	mac_res_t              res;
	acc_cmd_t              cmd;
	logic                  acc_free;

	assign plaq.ready = (state_q == StIdle);
	assign accept     = plaq.valid && plaq.ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			step_q  <= '0;
		end else begin
			case (state_q)
				StIdle: begin
					step_q <= '0;
					if (accept) begin
						state_q <= StRun;
					end
				end
				StRun: begin
					if (step_q == StepBits'(LastStep)) begin
						state_q <= StUpd;
					end else begin
						step_q <= step_q + StepBits'(1);
					end
				end
				StUpd: begin
					if (acc_free) begin
						state_q <= StIdle;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// capture the links of an accepted plaquette
	always_ff @(posedge clk) begin
		if (accept) begin
			a1_q      <= unpack_cplx(plaq.link1_diag);
			b1_q      <= unpack_cplx(plaq.link1_offdiag);
			a2_q      <= unpack_cplx(plaq.link2_diag);
			b2_q      <= unpack_cplx(plaq.link2_offdiag);
			a3_q      <= unpack_cplx(plaq.link3_diag);
			b3_q      <= unpack_cplx(plaq.link3_offdiag);
			a4_q      <= unpack_cplx(plaq.link4_diag);
			b4_q      <= unpack_cplx(plaq.link4_offdiag);
			is_time_q <= plaq.is_time;
			last_q    <= plaq.last;
		end
	end

	// issue schedule: two products per intermediate, first term always added
	always_comb begin
		ctl = '0;
		x   = a1_q;
		y   = a2_q;
		if (state_q == StRun) begin
			case (step_q)
				StepBits'(0): begin
					ctl.issue = 1'b1;
				end
				StepBits'(1): begin
					x = b1_q; y = b2_q;
					ctl.issue = 1'b1; ctl.conj = 1'b1; ctl.sub = 1'b1;
					ctl.fin = 1'b1; ctl.dest = DstS11;
				end
				StepBits'(2): begin
					x = a1_q; y = b2_q;
					ctl.issue = 1'b1;
				end
				StepBits'(3): begin
					x = b1_q; y = a2_q;
					ctl.issue = 1'b1; ctl.conj = 1'b1;
					ctl.fin = 1'b1; ctl.dest = DstS12;
				end
				StepBits'(4): begin
					x = s11_q; y = a3_q;
					ctl.issue = 1'b1; ctl.conj = 1'b1;
				end
				StepBits'(5): begin
					x = s12_q; y = b3_q;
					ctl.issue = 1'b1; ctl.conj = 1'b1;
					ctl.fin = 1'b1; ctl.dest = DstT11;
				end
				StepBits'(6): begin
					x = s12_q; y = a3_q;
					ctl.issue = 1'b1;
				end
				StepBits'(7): begin
					x = s11_q; y = b3_q;
					ctl.issue = 1'b1; ctl.sub = 1'b1;
					ctl.fin = 1'b1; ctl.dest = DstT12;
				end
				StepBits'(8): begin
					x = t11_q; y = a4_q;
					ctl.issue = 1'b1; ctl.conj = 1'b1;
				end
				StepBits'(9): begin
					x = t12_q; y = b4_q;
					ctl.issue = 1'b1; ctl.conj = 1'b1;
					ctl.fin = 1'b1; ctl.dest = DstP;
				end
				default: begin
					ctl = '0;
				end
			endcase
		end
	end

	su2pa_cmac u_cmac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.x      (x),
		.y      (y),
		.res    (res)
	);

	// write back finished intermediates
	always_ff @(posedge clk) begin
		if (res.valid) begin
			case (res.dest)
				DstS11:  s11_q <= res.value;
				DstS12:  s12_q <= res.value;
				DstT11:  t11_q <= res.value;
				DstT12:  t12_q <= res.value;
				DstP:    p_q   <= res.value.re;
				default: p_q   <= p_q;
			endcase
		end
	end

	assign cmd.upd     = (state_q == StUpd);
	assign cmd.is_time = is_time_q;
	assign cmd.last    = last_q;

	su2pa_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pv        (p_q),
		.ready     (sums.ready),
		.free      (acc_free),
		.valid     (sums.valid),
		.space_sum (sums.space_sum),
		.time_sum  (sums.time_sum)
	);

endmodule

>>> rtl/su2pa_checker.sv
// su2pa_checker: port-level assertions for su2_plaquette_accumulator,
// attached to the top level by the bind at the end of this file.
// depends on su2pa_pkg and su2_plaquette_accumulator.
module su2pa_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [su2pa_pkg::AccBits-1:0]  space_sum,
	input logic signed [su2pa_pkg::AccBits-1:0]  time_sum
);
	import su2pa_pkg::*;

	// busy right after a transaction is taken in
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready high right after a transaction");

	// the block is still busy in the drain step that follows the issue steps
	a_busy_through_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##11 !in_ready)
		else $error("input ready high before the product sequence ended");

	// new sums appear only out of the update step
	a_out_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("output valid rose while the block was idle");

	// stalled sums hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(space_sum) && $stable(time_sum))
		else $error("stalled output transaction changed");

endmodule

bind su2_plaquette_accumulator su2pa_checker u_su2pa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (plaq.valid),
	.in_ready  (plaq.ready),
	.out_valid (sums.valid),
	.out_ready (sums.ready),
	.space_sum (sums.space_sum),
	.time_sum  (sums.time_sum)
);
